>>> src/sound_command_stream_converter_top_macros.svh
// Assertion macros of the sound command stream converter top.
`ifndef SOUND_COMMAND_STREAM_CONVERTER_TOP_MACROS_SVH
`define SOUND_COMMAND_STREAM_CONVERTER_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SCSC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scsc: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SCSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scsc: next-cycle check failed");

`endif

>>> src/scsc_pkg.sv
// Types and constants of the sound command stream converter.
package scsc_pkg;

   // One input word: a raw file byte and the new-file mark.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       file_start;
   } req_type;

   // One result word.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       kind;
      logic       run_last;
      logic       stream_end;
   } rsp_type;

   // Up to two results produced by one input word.
   typedef struct packed {
      rsp_type    first;
      rsp_type    second;
      logic [1:0] count;
   } push_type;

   // Parser phases, one-hot.
   typedef enum logic [5:0] {
      PH_HEADER = 6'b000001,
      PH_SKIP   = 6'b000010,
      PH_CMD    = 6'b000100,
      PH_ARGS   = 6'b001000,
      PH_DONE   = 6'b010000,
      PH_BAD    = 6'b100000
   } phase_type;

   // Command codes of the input stream.
   localparam logic [7:0] CMD_WRITE = 8'h54;
   localparam logic [7:0] CMD_WAIT  = 8'h61;
   localparam logic [7:0] CMD_TICK  = 8'h62;
   localparam logic [7:0] CMD_END   = 8'h66;
   localparam logic [7:0] CMD_SKIP3 = 8'hc0;

   // Codes of the output stream.
   localparam logic [7:0] CODE_DELAY = 8'd2;
   localparam logic [7:0] CODE_DONE  = 8'd4;

   // Result kinds.
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_BAD  = 1'b1;

   // File signature, byte 0 first.
   localparam logic [7:0] SIGNATURE [0:3] = '{8'h56, 8'h67, 8'h6d, 8'h20};

   // Header layout.
   localparam int OFFSET_WIDTH = 32;
   localparam int OFFSET_BASE  = 'h34;
   localparam int FIRST_DATA   = 'h38;

   // Division of a 16-bit sample count by 735: (s * 91305) >> 26 is exact.
   localparam logic [16:0] RECIP_MULT  = 17'd91305;
   localparam int          RECIP_SHIFT = 26;
   localparam int          QUOT_WIDTH  = 7;

endpackage

>>> src/scsc_rsp_fifo.sv
// Four-entry result queue between the parser and the result channel.
module scsc_rsp_fifo
   import scsc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output rsp_type  head,
   output logic [2:0] level
);

   rsp_type    mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] level_ff, level_in;

   // Pointer and fill level bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      level_in  = level_ff + 3'(push.count) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry storage; the second result goes behind the first.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign level = level_ff;

endmodule

>>> src/scsc_parser.sv
// Header check, offset skip and command decode for one registered input word.
module scsc_parser
   import scsc_pkg::*;
#(
   parameter int POSITION_WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     fire,
   input  req_type  req,
   output push_type push
);

   localparam int SUM_WIDTH = OFFSET_WIDTH + 1;
   localparam logic [POSITION_WIDTH-1:0] POS_MAX   = {POSITION_WIDTH{1'b1}};
   localparam logic [SUM_WIDTH-1:0]      SUM_LIMIT = SUM_WIDTH'(POS_MAX);
   localparam logic [SUM_WIDTH-1:0]      SUM_FIRST = SUM_WIDTH'(FIRST_DATA);
   localparam logic [POSITION_WIDTH-1:0] POS_BASE  = POSITION_WIDTH'(OFFSET_BASE);
   localparam logic [POSITION_WIDTH-1:0] POS_FIRST = POSITION_WIDTH'(FIRST_DATA);

   phase_type                 phase_ff, phase_in;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [OFFSET_WIDTH-1:0]   offset_ff, offset_in;
   logic                      hdr_ok_ff, hdr_ok_in;
   logic [7:0]                pending_ff, pending_in;
   logic [1:0]                args_ff, args_in;
   logic [7:0]                wait_low_ff, wait_low_in;

   // State as seen by this word: a new file starts from the reset values.
   phase_type                 cur_phase;
   logic [POSITION_WIDTH-1:0] cur_pos;
   logic [OFFSET_WIDTH-1:0]   cur_offset;
   logic                      cur_hdr_ok;
   logic [7:0]                cur_pending;
   logic [1:0]                cur_args;
   logic [7:0]                cur_wait_low;

   logic [7:0]                b;
   logic                      run_cmd;
   logic                      sig_match;
   logic [OFFSET_WIDTH-1:0]   gathered;
   logic [SUM_WIDTH-1:0]      start_sum;
   logic [15:0]               samples;
   logic [32:0]               product;
   logic [7:0]                ticks;

   assign b = req.in_byte;

   always_comb begin
      if (req.file_start) begin
         cur_phase    = PH_HEADER;
         cur_pos      = '0;
         cur_offset   = '0;
         cur_hdr_ok   = 1'b1;
         cur_pending  = '0;
         cur_args     = '0;
         cur_wait_low = '0;
      end else begin
         cur_phase    = phase_ff;
         cur_pos      = pos_ff;
         cur_offset   = offset_ff;
         cur_hdr_ok   = hdr_ok_ff;
         cur_pending  = pending_ff;
         cur_args     = args_ff;
         cur_wait_low = wait_low_ff;
      end
   end

   // Offset gathering and the clamped start position.
   always_comb begin
      gathered  = cur_offset | (OFFSET_WIDTH'(b) << {cur_pos[1:0], 3'b000});
      start_sum = SUM_WIDTH'(gathered) + SUM_WIDTH'(OFFSET_BASE);
      if (start_sum > SUM_LIMIT) begin
         start_sum = SUM_LIMIT;
      end
      if (start_sum < SUM_FIRST) begin
         start_sum = SUM_FIRST;
      end
   end

   // Wait count in ticks: sample count over 735 by reciprocal multiply.
   always_comb begin
      samples = {b, cur_wait_low};
      product = 33'(samples) * 33'(RECIP_MULT);
      ticks   = 8'(product[RECIP_SHIFT +: QUOT_WIDTH]);
   end

   assign sig_match = (b == SIGNATURE[cur_pos[1:0]]);

   // Phase handling and result generation.
   always_comb begin
      phase_in    = cur_phase;
      offset_in   = cur_offset;
      hdr_ok_in   = cur_hdr_ok;
      pending_in  = cur_pending;
      args_in     = cur_args;
      wait_low_in = cur_wait_low;
      pos_in      = (cur_pos != POS_MAX) ? cur_pos + POSITION_WIDTH'(1) : cur_pos;
      run_cmd     = 1'b0;
      push        = '0;

      unique case (cur_phase)
         PH_HEADER: begin
            if (cur_pos < POSITION_WIDTH'(4)) begin
               hdr_ok_in = cur_hdr_ok && sig_match;
               if (cur_pos == POSITION_WIDTH'(3) && !hdr_ok_in) begin
                  push.first = '{out_byte: 8'd0, kind: KIND_BAD, run_last: 1'b1,
                                 stream_end: 1'b0};
                  push.count = 2'd1;
                  phase_in   = PH_BAD;
               end
            end else if (cur_pos >= POS_BASE && cur_pos < POS_FIRST) begin
               offset_in = gathered;
               if (cur_pos == POS_FIRST - POSITION_WIDTH'(1)) begin
                  offset_in = OFFSET_WIDTH'(start_sum);
                  phase_in  = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            if (cur_pos == cur_offset[POSITION_WIDTH-1:0]) begin
               phase_in = PH_CMD;
               run_cmd  = 1'b1;
            end
         end
         PH_CMD: begin
            run_cmd = 1'b1;
         end
         PH_ARGS: begin
            if (cur_pending == CMD_WRITE) begin
               push.first = '{out_byte: b, kind: KIND_DATA, run_last: 1'b1,
                              stream_end: 1'b0};
               push.count = 2'd1;
            end else if (cur_pending == CMD_WAIT) begin
               if (cur_args == 2'd2) begin
                  wait_low_in = b;
               end else begin
                  push.first  = '{out_byte: CODE_DELAY, kind: KIND_DATA, run_last: 1'b0,
                                  stream_end: 1'b0};
                  push.second = '{out_byte: ticks, kind: KIND_DATA, run_last: 1'b1,
                                  stream_end: 1'b0};
                  push.count  = 2'd2;
               end
            end
            args_in = (cur_args != 2'd0) ? cur_args - 2'd1 : 2'd0;
            if (args_in == 2'd0) begin
               phase_in = PH_CMD;
            end
         end
         default: begin
         end
      endcase

      // Command decode.
      if (run_cmd) begin
         unique case (b) inside
            CMD_WRITE, CMD_WAIT: begin
               pending_in = b;
               args_in    = 2'd2;
               phase_in   = PH_ARGS;
            end
            CMD_SKIP3: begin
               pending_in = b;
               args_in    = 2'd3;
               phase_in   = PH_ARGS;
            end
            CMD_TICK: begin
               push.first  = '{out_byte: CODE_DELAY, kind: KIND_DATA, run_last: 1'b0,
                               stream_end: 1'b0};
               push.second = '{out_byte: 8'd1, kind: KIND_DATA, run_last: 1'b1,
                               stream_end: 1'b0};
               push.count  = 2'd2;
            end
            CMD_END: begin
               push.first  = '{out_byte: CODE_DONE, kind: KIND_DATA, run_last: 1'b0,
                               stream_end: 1'b0};
               push.second = '{out_byte: 8'd0, kind: KIND_DATA, run_last: 1'b1,
                               stream_end: 1'b1};
               push.count  = 2'd2;
               phase_in    = PH_DONE;
            end
            default: begin
            end
         endcase
      end

      // Nothing leaves the parser unless a word is processed.
      if (!fire) begin
         push = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         pos_ff      <= '0;
         offset_ff   <= '0;
         hdr_ok_ff   <= 1'b1;
         pending_ff  <= '0;
         args_ff     <= '0;
         wait_low_ff <= '0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         offset_ff   <= offset_in;
         hdr_ok_ff   <= hdr_ok_in;
         pending_ff  <= pending_in;
         args_ff     <= args_in;
         wait_low_ff <= wait_low_in;
      end
   end

endmodule

>>> src/sound_command_stream_converter_top.sv
// Sound command stream converter: file bytes in, converted command stream out.
//
// The req channel takes one file byte per word; file_start marks byte 0 of a
// new file and restarts parsing. The rsp channel gives the converted words:
// register/value bytes, delay codes and counts, the end code pair, or one
// bad-signature word. A word moves on a channel at a clock edge with valid
// high and stall low. An input word is held in an input register, decoded
// by the parser once the queue has room for two results, and its zero, one
// or two results are written to a four-entry result queue. The first result
// of a word is offered on rsp once it is in the queue; a second result
// follows behind it. Input words are taken every cycle while the queue has
// room for two results; the result channel moves one word per cycle while
// rsp_stall is low, so a run of two-result commands is paced by the result
// channel. If the receiver stalls, the queue fills and req_stall rises; the
// head result holds steady meanwhile. Synchronous reset empties the input
// register and the queue and returns the parser to the header phase at byte 0.
`include "sound_command_stream_converter_top_macros.svh"

module sound_command_stream_converter_top
   import scsc_pkg::*;
#(
   parameter int POSITION_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff;
   logic       req_accept;
   logic       fire;
   logic       room;
   logic       pop;
   logic [2:0] level;
   push_type   push;

   // Input register: a held word is processed once the queue has room for two.
   assign room       = (level <= 3'd2);
   assign fire       = in_valid_ff && room;
   assign req_stall  = in_valid_ff && !room;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_payload;
      end
   end

   scsc_parser #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .fire (fire),
      .req  (in_data_ff),
      .push (push)
   );

   // Result queue feeding the rsp channel.
   assign rsp_valid = (level != 3'd0);
   assign pop       = rsp_valid && !rsp_stall;

   scsc_rsp_fifo u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .push (push),
      .pop  (pop),
      .head (rsp_payload),
      .level(level)
   );

   // The input side stalls only while it holds an undelivered word.
   `SCSC_ASSERT_SAME(a_stall_has_word, req_stall, in_valid_ff)
   // Results appear only for processed words.
   `SCSC_ASSERT_SAME(a_push_needs_fire, push.count != 2'd0, fire)
   // A pair of results closes on the second one only.
   `SCSC_ASSERT_SAME(a_pair_last, push.count == 2'd2,
                     push.second.run_last && !push.first.run_last)
   // A written result is offered on the next cycle.
   `SCSC_ASSERT_NEXT(a_push_shows, push.count != 2'd0, rsp_valid)

endmodule
